>>> rtl/core/tsd_pkg.sv
package tsd_pkg;

    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_INCHES_PER_REV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_VELOCITY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_REFERENCE = 3'd5;

    localparam logic signed [31:0] GYRO_SCALE_RESET = 32'sd65536;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_DIV_STEP,
        S_CAP_STEP,
        S_MUL_VV,
        S_DIV_STOP,
        S_WAIT_STOP,
        S_VEL,
        S_CHECK,
        S_DIV_POS,
        S_PLAN,
        S_MT_L,
        S_MT_R,
        S_MG,
        S_MRPM,
        S_MH,
        S_ML,
        S_MR,
        S_MCAP,
        S_RES_DRIVE,
        S_RES_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_START,
        OP_DIV_STEP,
        OP_CAP_STEP,
        OP_MUL_VV,
        OP_DIV_STOP,
        OP_VEL,
        OP_DIV_POS,
        OP_PLAN,
        OP_MT_L,
        OP_MT_R,
        OP_MG,
        OP_MRPM,
        OP_MH,
        OP_ML,
        OP_MR,
        OP_MCAP,
        OP_RES_DRIVE,
        OP_RES_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic active;
        logic goal_zero;
        logic div_busy;
        logic vneg;
        logic out_free;
    } status_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        return sat64(p >>> 16);
    endfunction

endpackage

>>> rtl/core/tsd_div.sv
module tsd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    input  logic [tsd_pkg::DIV_CNT_W-1:0] iters,
    output logic        busy,
    output logic [63:0] quotient
);
    import tsd_pkg::*;

    logic [63:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic        busy_reg;
    logic [32:0] rem_sh;
    logic [33:0] sub;
    logic        ge;

    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign sub    = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge     = ~sub[33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            rem_reg <= ge ? sub[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/core/tsd_ctrl.sv
module tsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tsd_pkg::status_t status,
    output tsd_pkg::cmd_t    cmd
);
    import tsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (!status.mode)
                    state_next = S_START;
                else if (status.active)
                    state_next = S_MUL_VV;
                else
                    state_next = S_IDLE;
            end
            S_START:     state_next = status.goal_zero ? S_RES_DONE : S_DIV_STEP;
            S_DIV_STEP:  state_next = S_CAP_STEP;
            S_CAP_STEP:  state_next = S_IDLE;
            S_MUL_VV:    state_next = S_DIV_STOP;
            S_DIV_STOP:  state_next = S_WAIT_STOP;
            S_WAIT_STOP: if (!status.div_busy) state_next = S_VEL;
            S_VEL:       state_next = S_CHECK;
            S_CHECK:     state_next = status.vneg ? S_RES_DONE : S_DIV_POS;
            S_DIV_POS:   state_next = S_PLAN;
            S_PLAN:      state_next = S_MT_L;
            S_MT_L:      state_next = S_MT_R;
            S_MT_R:      state_next = S_MG;
            S_MG:        state_next = S_MRPM;
            S_MRPM:      state_next = S_MH;
            S_MH:        state_next = S_ML;
            S_ML:        state_next = S_MR;
            S_MR:        state_next = S_MCAP;
            S_MCAP:      state_next = S_RES_DRIVE;
            S_RES_DRIVE: if (status.out_free) state_next = S_IDLE;
            S_RES_DONE:  if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LATCH;
            end
            S_START:     cmd.op = OP_START;
            S_DIV_STEP:  cmd.op = OP_DIV_STEP;
            S_CAP_STEP:  cmd.op = OP_CAP_STEP;
            S_MUL_VV:    cmd.op = OP_MUL_VV;
            S_DIV_STOP:  cmd.op = OP_DIV_STOP;
            S_VEL:       cmd.op = OP_VEL;
            S_DIV_POS:   cmd.op = OP_DIV_POS;
            S_PLAN:      cmd.op = OP_PLAN;
            S_MT_L:      cmd.op = OP_MT_L;
            S_MT_R:      cmd.op = OP_MT_R;
            S_MG:        cmd.op = OP_MG;
            S_MRPM:      cmd.op = OP_MRPM;
            S_MH:        cmd.op = OP_MH;
            S_ML:        cmd.op = OP_ML;
            S_MR:        cmd.op = OP_MR;
            S_MCAP:      cmd.op = OP_MCAP;
            S_RES_DRIVE: cmd.op = OP_RES_DRIVE;
            S_RES_DONE:  cmd.op = OP_RES_DONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/core/tsd_dp.sv
module tsd_dp #(
    parameter int TICKS_PER_SECOND = 50
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsd_pkg::cmd_t                       cmd,
    output tsd_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [tsd_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tsd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import tsd_pkg::*;

    localparam logic [31:0] TPS = 32'(TICKS_PER_SECOND);
    // x / TPS == (x * RECIP_M) >> RECIP_SH for any 31-bit x
    localparam int          RECIP_SH   = 31 + $clog2(TICKS_PER_SECOND);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) + 64'(TPS) - 64'd1) / 64'(TPS);
    localparam logic [31:0] RECIP_M    = RECIP_FULL[31:0];

    logic [30:0]        ipr_reg, rpv_reg;
    logic signed [31:0] kp_reg, kh_reg, gs_reg, href_reg;

    logic               in_mode_reg;
    logic signed [31:0] in_goal_reg, in_lpos_reg, in_rpos_reg, in_gyro_reg;
    logic [30:0]        in_maxv_reg, in_acc_reg;

    logic               active_reg, reverse_reg, vneg_reg;
    logic signed [31:0] vel_reg, plan_reg, lstart_reg, rstart_reg, goal_reg;
    logic [30:0]        limit_reg, accel_reg, step_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] trav_l_reg, trav_r_reg, eh_reg, rpm_reg, head_reg, pl_reg, pr_reg;
    logic signed [31:0] right_reg, left_reg;
    logic               done_reg, out_valid_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [30:0]        recip_q;
    logic signed [31:0] diff_l, diff_r, err_l, err_r;
    logic               div_start, div_busy;
    logic [63:0]        div_dividend, div_quotient;
    logic [31:0]        div_divisor;
    logic [DIV_CNT_W-1:0] div_iters;
    logic signed [63:0] stop, vel_next, rpm_s;
    logic               brake, out_free;

    tsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipr_reg  <= '0;
            rpv_reg  <= '0;
            kp_reg   <= '0;
            kh_reg   <= '0;
            gs_reg   <= GYRO_SCALE_RESET;
            href_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INCHES_PER_REV:    ipr_reg  <= cfg_data[30:0];
                CFG_RPM_PER_VELOCITY:  rpv_reg  <= cfg_data[30:0];
                CFG_POSITION_GAIN:     kp_reg   <= cfg_data;
                CFG_HEADING_GAIN:      kh_reg   <= cfg_data;
                CFG_GYRO_SCALE:        gs_reg   <= cfg_data;
                CFG_HEADING_REFERENCE: href_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign diff_l = sat64(64'(in_lpos_reg) - 64'(lstart_reg));
    assign diff_r = sat64(64'(in_rpos_reg) - 64'(rstart_reg));
    assign err_l  = sat64(64'(plan_reg) - 64'(trav_l_reg));
    assign err_r  = sat64(64'(plan_reg) - 64'(trav_r_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DIV_STEP: begin mul_a = {2'b00, in_acc_reg}; mul_b = {1'b0, RECIP_M};  end
            OP_DIV_POS:  begin mul_a = 33'(vel_reg);     mul_b = {1'b0, RECIP_M};     end
            OP_MUL_VV:   begin mul_a = 33'(vel_reg);     mul_b = 33'(vel_reg);        end
            OP_MT_L:     begin mul_a = 33'(diff_l);      mul_b = {2'b00, ipr_reg};    end
            OP_MT_R:     begin mul_a = 33'(diff_r);      mul_b = {2'b00, ipr_reg};    end
            OP_MG:       begin mul_a = 33'(in_gyro_reg); mul_b = 33'(gs_reg);         end
            OP_MRPM:     begin mul_a = 33'(vel_reg);     mul_b = {2'b00, rpv_reg};    end
            OP_MH:       begin mul_a = 33'(kh_reg);      mul_b = 33'(eh_reg);         end
            OP_ML:       begin mul_a = 33'(kp_reg);      mul_b = 33'(err_l);          end
            OP_MR:       begin mul_a = 33'(kp_reg);      mul_b = 33'(err_r);          end
            default:     begin mul_a = '0;               mul_b = '0;                  end
        endcase
    end

    assign recip_q = 31'(prod_reg >> RECIP_SH);

    always_comb
    begin
        div_start    = (cmd.op == OP_DIV_STOP);
        div_dividend = {prod_reg[61:0], 2'b00};
        div_divisor  = {accel_reg, 1'b0};
        div_iters    = DIV_CNT_W'(62);
    end

    assign stop = $signed(div_quotient);

    always_comb
    begin
        if (reverse_reg)
            brake = (64'(plan_reg) - stop) <= 64'(goal_reg);
        else
            brake = (64'(plan_reg) + stop) >= 64'(goal_reg);
        brake = brake || (accel_reg == '0);
        if (brake)
            vel_next = 64'(vel_reg) - $signed({33'd0, step_reg});
        else if (vel_reg < $signed({1'b0, limit_reg}))
            vel_next = 64'(sat64(64'(vel_reg) + $signed({33'd0, step_reg})));
        else
            vel_next = $signed({33'd0, limit_reg});
    end

    assign out_free = !out_valid_reg || m_tready;
    assign rpm_s    = reverse_reg ? -64'(rpm_reg) : 64'(rpm_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.op)
            OP_LATCH:
            begin
                in_mode_reg <= s_tuser;
                in_goal_reg <= s_tdata[31:0];
                in_maxv_reg <= s_tdata[62:32];
                in_acc_reg  <= s_tdata[93:63];
                in_lpos_reg <= s_tdata[125:94];
                in_rpos_reg <= s_tdata[157:126];
                in_gyro_reg <= s_tdata[189:158];
            end
            OP_START:
            begin
                goal_reg   <= in_goal_reg;
                limit_reg  <= in_maxv_reg;
                accel_reg  <= in_acc_reg;
                lstart_reg <= in_lpos_reg;
                rstart_reg <= in_rpos_reg;
                vel_reg    <= '0;
                plan_reg   <= '0;
            end
            OP_CAP_STEP: step_reg <= recip_q;
            OP_VEL:      vel_reg  <= vel_next[31:0];
            OP_PLAN:
            begin
                if (reverse_reg)
                    plan_reg <= sat64(64'(plan_reg) - $signed({33'd0, recip_q}));
                else
                    plan_reg <= sat64(64'(plan_reg) + $signed({33'd0, recip_q}));
            end
            OP_MT_R:  trav_l_reg <= qsat(prod_reg);
            OP_MG:    trav_r_reg <= qsat(prod_reg);
            OP_MRPM:  eh_reg     <= sat64(64'(qsat(prod_reg)) - 64'(href_reg));
            OP_MH:    rpm_reg    <= qsat(prod_reg);
            OP_ML:    head_reg   <= qsat(prod_reg);
            OP_MR:    pl_reg     <= qsat(prod_reg);
            OP_MCAP:  pr_reg     <= qsat(prod_reg);
            OP_RES_DRIVE:
            begin
                if (out_free)
                begin
                    right_reg <= sat64(64'(pr_reg) + rpm_s + 64'(head_reg));
                    left_reg  <= sat64(64'(pl_reg) + rpm_s - 64'(head_reg));
                    done_reg  <= 1'b0;
                end
            end
            OP_RES_DONE:
            begin
                if (out_free)
                begin
                    right_reg <= '0;
                    left_reg  <= '0;
                    done_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            reverse_reg   <= 1'b0;
            vneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_START:
                begin
                    active_reg  <= (in_goal_reg != '0);
                    reverse_reg <= in_goal_reg[31];
                    vneg_reg    <= 1'b0;
                end
                OP_VEL:      vneg_reg   <= vel_next[63];
                OP_RES_DONE: if (out_free) active_reg <= 1'b0;
                default: ;
            endcase
            if ((cmd.op == OP_RES_DRIVE || cmd.op == OP_RES_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.mode      = in_mode_reg;
    assign status.active    = active_reg;
    assign status.goal_zero = (in_goal_reg == '0);
    assign status.div_busy  = div_busy;
    assign status.vneg      = vneg_reg;
    assign status.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {left_reg, right_reg};
    assign m_tlast  = done_reg;

`ifndef SYNTH
    a_vel_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !vneg_reg) |-> !vel_reg[31])
        else $error("velocity negative during a running move");
    a_plan_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !reverse_reg) |-> !plan_reg[31])
        else $error("forward planned position went negative");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

>>> rtl/core/trapezoid_straight_drive.sv
// control tick: v*v product, 62-step serial divide for the stopping distance, velocity
// update, planned position, multiply chain, drive result; final tick: done, zero drive
// start: latch the move and its velocity step, back to idle; zero distance: done result
// one item at a time; a waiting result stalls the next result and with it the next input
// rst_n is asynchronous active low: move idle, output empty, gyro_scale 1.0
module trapezoid_straight_drive #(
    parameter int TICKS_PER_SECOND = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // target_distance, max_velocity, acceleration, left_position,
    // right_position, gyro_heading, zero pad
    input  logic [tsd_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // right_drive, left_drive
    output logic [tsd_pkg::OUT_DATA_W-1:0] m_tdata,
    // done_res
    output logic                           m_tlast
);
    import tsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    tsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsd_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
